FILE: sv/spig_pkg.sv
`default_nettype none

package spig_pkg;

    localparam int unsigned SIDE_BITS_DEF = 16;
    localparam int unsigned POS_W         = 32;
    localparam int unsigned CFG_W         = 16;
    localparam int unsigned COORD_W       = 16;
    localparam int unsigned ROOT_W        = POS_W / 2;
    localparam int unsigned REM_W         = ROOT_W + 2;
    localparam int unsigned SQRT_ITERS    = 2;
    localparam int unsigned SQRT_STAGES   = ROOT_W / SQRT_ITERS;
    localparam int unsigned K_W           = ROOT_W + 2;
    localparam int unsigned D_W           = ROOT_W + 4;

    typedef enum logic [1:0] {
        SEG_UP    = 2'd0,
        SEG_LEFT  = 2'd1,
        SEG_DOWN  = 2'd2,
        SEG_RIGHT = 2'd3
    } t_seg;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic              in_range;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } t_sqrt_data;

    typedef struct packed {
        logic           in_range;
        logic [K_W-1:0] seg;
        logic [D_W-1:0] d;
    } t_ring_data;

    typedef struct packed {
        logic               in_range;
        t_seg               code;
        logic [COORD_W-1:0] off;
        logic [COORD_W-1:0] hi;
        logic [COORD_W-1:0] lo;
    } t_seg_data;

    typedef struct packed {
        logic [COORD_W-1:0] line;
        logic [COORD_W-1:0] column;
        logic               valid_res;
    } t_res_data;

    // one restoring square-root digit, consumes position bits [2*idx+1:2*idx]
    function automatic t_sqrt_data sqrt_step(input t_sqrt_data x, input int unsigned idx);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        t_sqrt_data       y;
        y      = x;
        rem_sh = {x.rem[REM_W-3:0], x.pos[2*idx +: 2]};
        trial  = {x.root, 2'b01};
        if (rem_sh >= trial) begin
            y.rem  = rem_sh - trial;
            y.root = {x.root[ROOT_W-2:0], 1'b1};
        end else begin
            y.rem  = rem_sh;
            y.root = {x.root[ROOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

`default_nettype wire

FILE: sv/spig_if.sv
`default_nettype none

interface spig_pos_if;
    logic                         valid;
    logic                         ready;
    logic [spig_pkg::POS_W-1:0]   position;
    modport source  (output valid, output position, input ready);
    modport sink    (input valid, input position, output ready);
    modport monitor (input valid, input position, input ready);
endinterface

interface spig_res_if;
    logic                         valid;
    logic                         ready;
    logic [spig_pkg::COORD_W-1:0] line;
    logic [spig_pkg::COORD_W-1:0] column;
    logic                         valid_res;
    modport source  (output valid, output line, output column, output valid_res, input ready);
    modport sink    (input valid, input line, input column, input valid_res, output ready);
    modport monitor (input valid, input line, input column, input valid_res, input ready);
endinterface

`default_nettype wire

FILE: sv/spig_sqrt.sv
`default_nettype none

module spig_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [spig_pkg::POS_W-1:0]   i_in_pos,
    input  wire logic [spig_pkg::POS_W-1:0]   i_side_sq,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output spig_pkg::t_sqrt_data              o_out_data
);

    localparam int unsigned N = spig_pkg::SQRT_STAGES;

    logic [N-1:0]         r_vld;
    spig_pkg::t_sqrt_data r_dat [N];
    logic [N:0]           w_rdy;
    spig_pkg::t_sqrt_data w_entry;

    always_comb begin
        w_entry          = '0;
        w_entry.pos      = i_in_pos;
        w_entry.in_range = (i_in_pos != '0) && (i_in_pos <= i_side_sq);
    end

    assign w_rdy[N] = i_out_ready;

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic                 w_src_vld;
        spig_pkg::t_sqrt_data w_src;
        spig_pkg::t_sqrt_data n_dat;

        if (s == 0) begin : g_first
            assign w_src_vld = i_in_valid;
            assign w_src     = w_entry;
        end else begin : g_next
            assign w_src_vld = r_vld[s-1];
            assign w_src     = r_dat[s-1];
        end

        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];

        always_comb begin
            n_dat = w_src;
            for (int unsigned j = 0; j < spig_pkg::SQRT_ITERS; j++) begin
                n_dat = spig_pkg::sqrt_step(n_dat,
                            spig_pkg::ROOT_W - 1 - s * spig_pkg::SQRT_ITERS - j);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= w_src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && w_src_vld) begin
                r_dat[s] <= n_dat;
            end
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[N-1];
    assign o_out_data  = r_dat[N-1];

endmodule

`default_nettype wire

FILE: sv/spig_place.sv
`default_nettype none

module spig_place (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire spig_pkg::t_sqrt_data           i_in_data,
    input  wire logic [spig_pkg::COORD_W-1:0]   i_mid,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output spig_pkg::t_res_data                 o_out_data
);

    localparam int unsigned K_W = spig_pkg::K_W;
    localparam int unsigned D_W = spig_pkg::D_W;
    localparam int unsigned C_W = spig_pkg::COORD_W;

    logic [2:0] r_vld;
    logic [3:0] w_rdy;

    spig_pkg::t_ring_data r_ring;
    spig_pkg::t_ring_data n_ring;
    spig_pkg::t_seg_data  r_seg;
    spig_pkg::t_seg_data  n_seg;
    spig_pkg::t_res_data  r_res;
    spig_pkg::t_res_data  n_res;

    assign w_rdy[3] = i_out_ready;
    assign w_rdy[2] = !r_vld[2] || w_rdy[3];
    assign w_rdy[1] = !r_vld[1] || w_rdy[2];
    assign w_rdy[0] = !r_vld[0] || w_rdy[1];

    // ring side k and offset d from root and remainder
    always_comb begin
        logic [K_W-1:0] r_k;
        logic [K_W-1:0] k;
        logic [D_W-1:0] two_r1;
        logic [D_W-1:0] four_r4;
        logic [D_W-1:0] rem_d;
        r_k     = K_W'(i_in_data.root);
        two_r1  = (D_W'(i_in_data.root) << 1) + D_W'(1);
        four_r4 = (D_W'(i_in_data.root) << 2) + D_W'(4);
        rem_d   = D_W'(i_in_data.rem);
        n_ring          = '0;
        n_ring.in_range = i_in_data.in_range;
        if (i_in_data.rem == '0) begin
            if (i_in_data.root[0]) begin
                k        = r_k;
                n_ring.d = '0;
            end else begin
                k        = r_k + K_W'(1);
                n_ring.d = two_r1;
            end
        end else if (!i_in_data.root[0]) begin
            k        = r_k + K_W'(1);
            n_ring.d = two_r1 - rem_d;
        end else begin
            k        = r_k + K_W'(2);
            n_ring.d = four_r4 - rem_d;
        end
        n_ring.seg = k - K_W'(1);
    end

    // segment choice and corner coordinates
    always_comb begin
        logic [D_W-1:0] seg1;
        logic [D_W-1:0] seg2;
        logic [D_W-1:0] seg3;
        logic [C_W-1:0] h;
        seg1 = D_W'(r_ring.seg);
        seg2 = seg1 << 1;
        seg3 = seg2 + seg1;
        h    = C_W'(r_ring.seg >> 1);
        n_seg          = '0;
        n_seg.in_range = r_ring.in_range;
        n_seg.hi       = i_mid + h;
        n_seg.lo       = i_mid - h;
        if (r_ring.d <= seg1) begin
            n_seg.code = spig_pkg::SEG_UP;
            n_seg.off  = C_W'(r_ring.d);
        end else if (r_ring.d <= seg2) begin
            n_seg.code = spig_pkg::SEG_LEFT;
            n_seg.off  = C_W'(r_ring.d - seg1);
        end else if (r_ring.d <= seg3) begin
            n_seg.code = spig_pkg::SEG_DOWN;
            n_seg.off  = C_W'(r_ring.d - seg2);
        end else begin
            n_seg.code = spig_pkg::SEG_RIGHT;
            n_seg.off  = C_W'(r_ring.d - seg3);
        end
    end

    always_comb begin
        n_res = '0;
        if (r_seg.in_range) begin
            n_res.valid_res = 1'b1;
            case (r_seg.code)
                spig_pkg::SEG_UP: begin
                    n_res.line   = r_seg.hi - r_seg.off;
                    n_res.column = r_seg.hi;
                end
                spig_pkg::SEG_LEFT: begin
                    n_res.line   = r_seg.lo;
                    n_res.column = r_seg.hi - r_seg.off;
                end
                spig_pkg::SEG_DOWN: begin
                    n_res.line   = r_seg.lo + r_seg.off;
                    n_res.column = r_seg.lo;
                end
                spig_pkg::SEG_RIGHT: begin
                    n_res.line   = r_seg.hi;
                    n_res.column = r_seg.lo + r_seg.off;
                end
                default: begin
                    n_res.line   = '0;
                    n_res.column = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            if (w_rdy[1]) begin
                r_vld[1] <= r_vld[0];
            end
            if (w_rdy[2]) begin
                r_vld[2] <= r_vld[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_in_valid) begin
            r_ring <= n_ring;
        end
        if (w_rdy[1] && r_vld[0]) begin
            r_seg <= n_seg;
        end
        if (w_rdy[2] && r_vld[1]) begin
            r_res <= n_res;
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[2];
    assign o_out_data  = r_res;

endmodule

`default_nettype wire

FILE: sv/spiral_index_to_grid_position_core.sv
// Channel   Dir  Fields                          Transfer
// i_pos     in   position[31:0]                  valid && ready
// o_res     out  line[15:0] column[15:0]         valid && ready
//                valid_res
// i_cfg     in   i_cfg_wdata[15:0] (grid_side)   i_cfg_we
//
// 8 square-root stages (two root bits each) and 3 placement stages.
// One transfer per cycle sustained while o_res is ready; every stage holds a valid bit.
// A stall on o_res fills the bubbles upstream before i_pos.ready drops.
// Synchronous active-low reset empties the pipeline and sets grid_side to 1.
`default_nettype none

module spiral_index_to_grid_position_core #(
    parameter int unsigned SIDE_BITS = spig_pkg::SIDE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    spig_pos_if.sink                        i_pos,
    spig_res_if.source                      o_res,
    input  wire logic                       i_cfg_we,
    input  wire logic [spig_pkg::CFG_W-1:0] i_cfg_wdata
);

    localparam int unsigned SIDE_W = (SIDE_BITS < spig_pkg::CFG_W) ? SIDE_BITS : spig_pkg::CFG_W;
    localparam int unsigned POS_W  = spig_pkg::POS_W;
    localparam int unsigned C_W    = spig_pkg::COORD_W;

    logic [SIDE_W-1:0]   r_side;
    logic [POS_W-1:0]    r_side_sq;
    logic [SIDE_W-1:0]   w_side_new;
    logic [2*SIDE_W-1:0] w_side_sq;
    logic [C_W-1:0]      w_mid;

    logic                 w_sq_valid;
    logic                 w_sq_ready;
    spig_pkg::t_sqrt_data w_sq_data;
    spig_pkg::t_res_data  w_res;

    assign w_side_new = i_cfg_wdata[SIDE_W-1:0];
    assign w_side_sq  = w_side_new * w_side_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side    <= SIDE_W'(1);
            r_side_sq <= POS_W'(1);
        end else if (i_cfg_we) begin
            r_side    <= w_side_new;
            r_side_sq <= POS_W'(w_side_sq);
        end
    end

    assign w_mid = C_W'(r_side >> 1) + C_W'(1);

    spig_sqrt u_sqrt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pos.valid),
        .o_in_ready  (i_pos.ready),
        .i_in_pos    (i_pos.position),
        .i_side_sq   (r_side_sq),
        .o_out_valid (w_sq_valid),
        .i_out_ready (w_sq_ready),
        .o_out_data  (w_sq_data)
    );

    spig_place u_place (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_sq_valid),
        .o_in_ready  (w_sq_ready),
        .i_in_data   (w_sq_data),
        .i_mid       (w_mid),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_out_data  (w_res)
    );

    assign o_res.line      = w_res.line;
    assign o_res.column    = w_res.column;
    assign o_res.valid_res = w_res.valid_res;

endmodule

`default_nettype wire

FILE: sv/spig_checker.sv
`default_nettype none

module spig_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_pos_ready,
    input  wire logic                         i_res_valid,
    input  wire logic                         i_res_ready,
    input  wire logic [spig_pkg::COORD_W-1:0] i_res_line,
    input  wire logic [spig_pkg::COORD_W-1:0] i_res_column,
    input  wire logic                         i_res_valid_res
);

    // stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_line) && $stable(i_res_column)
            && $stable(i_res_valid_res))
        else $error("result changed under stall");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_valid_res |-> i_res_line == '0 && i_res_column == '0)
        else $error("invalid result with nonzero coordinates");

    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_valid_res |-> i_res_line != '0 && i_res_column != '0)
        else $error("valid result outside 1-based grid");

    // pipeline drains from empty: no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !i_res_valid && i_pos_ready)
        else $error("pipeline not empty after reset");

endmodule

bind spiral_index_to_grid_position_core spig_checker u_spig_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_pos_ready     (i_pos.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_line      (o_res.line),
    .i_res_column    (o_res.column),
    .i_res_valid_res (o_res.valid_res)
);

`default_nettype wire

FILE: sim/tb_spiral_index_to_grid_position_core.sv
`timescale 1ns / 1ps

module tb_spiral_index_to_grid_position_core;

    localparam int unsigned LATENCY      = 11;
    localparam int unsigned RAND_PER_SET = 52;
    localparam int unsigned NUM_SIDES    = 14;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [spig_pkg::CFG_W-1:0] i_cfg_wdata;

    spig_pos_if pos_if ();
    spig_res_if res_if ();

    spiral_index_to_grid_position_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pos       (pos_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    logic [spig_pkg::POS_W-1:0] position_q[$];
    spig_pkg::t_res_data        coord_expect_q[$];
    logic [spig_pkg::CFG_W-1:0] side_now;
    int unsigned                src_idle_pct;
    int unsigned                sink_idle_pct;
    logic                       sink_hold;
    logic                       hold_go;
    int unsigned                mismatches;

    // closed-form spiral placement
    function automatic spig_pkg::t_res_data place_on_spiral(
        input logic [spig_pkg::POS_W-1:0] pos,
        input logic [spig_pkg::CFG_W-1:0] side);
        bit [63:0] p, s, r, t, k, d, h, mid, seg, hi, lo, ln, cl;
        spig_pkg::t_res_data res;
        p   = 64'(pos);
        s   = 64'(side);
        res = '0;
        if (p != 0 && p <= s * s) begin
            r = 0;
            for (int i = 15; i >= 0; i--) begin
                t = r | (64'd1 << i);
                if (t * t <= p) r = t;
            end
            k = (r * r < p) ? r + 1 : r;
            if (!k[0]) k = k + 1;
            d   = k * k - p;
            h   = (k - 1) / 2;
            mid = s / 2 + 1;
            seg = k - 1;
            hi  = mid + h;
            lo  = mid - h;
            if (d <= seg) begin
                ln = hi - d;
                cl = hi;
            end else if (d <= 2 * seg) begin
                ln = lo;
                cl = hi - (d - seg);
            end else if (d <= 3 * seg) begin
                ln = lo + (d - 2 * seg);
                cl = lo;
            end else begin
                ln = hi;
                cl = lo + (d - 3 * seg);
            end
            res.line      = ln[spig_pkg::COORD_W-1:0];
            res.column    = cl[spig_pkg::COORD_W-1:0];
            res.valid_res = 1'b1;
        end
        return res;
    endfunction

    // mostly in-grid positions, ring corners and segment ends, some out of range
    function automatic logic [spig_pkg::POS_W-1:0] pick_position(
        input logic [spig_pkg::CFG_W-1:0] side);
        bit [63:0]   sq, k, c;
        int unsigned roll, kmax;
        sq   = 64'(side) * 64'(side);
        roll = $urandom_range(99);
        if (sq == 0 || roll < 12) return $urandom;
        if (roll < 14) return '0;
        if (roll < 16) return spig_pkg::POS_W'(sq + 1);
        if (roll < 40) begin
            kmax = (32'(side) - 32'd1) / 32'd2;
            k    = 2 * $urandom_range(kmax, 0) + 1;
            c    = k * k - $urandom_range(3, 0) * (k - 1);
            c    = c + $urandom_range(2, 0);
            c    = c - 1;
            return spig_pkg::POS_W'(c);
        end
        return $urandom_range(32'(sq), 1);
    endfunction

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pos_if.valid <= 1'b0;
        end else if (!pos_if.valid || pos_if.ready) begin
            if (position_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                pos_if.valid    <= 1'b1;
                pos_if.position <= position_q.pop_front();
            end else begin
                pos_if.valid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // long sink hold-off, backs the pipeline up into the input
    initial begin
        sink_hold = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (120) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        spig_pkg::t_res_data want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (coord_expect_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result transfer: line %0d column %0d valid_res %0b",
                                 res_if.line, res_if.column, res_if.valid_res);
                    mismatches++;
                end else begin
                    want = coord_expect_q.pop_front();
                    if (want.line != res_if.line || want.column != res_if.column ||
                        want.valid_res != res_if.valid_res) begin
                        if (mismatches < 10)
                            $display({"mismatch: exp line %0d column %0d valid_res %0b,",
                                      " got line %0d column %0d valid_res %0b"},
                                     want.line, want.column, want.valid_res,
                                     res_if.line, res_if.column, res_if.valid_res);
                        mismatches++;
                    end
                end
            end
            if (pos_if.valid && pos_if.ready)
                coord_expect_q.push_back(place_on_spiral(pos_if.position, side_now));
        end
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (position_q.size() != 0 || pos_if.valid || coord_expect_q.size() != 0);
    endtask

    task automatic write_side(input logic [spig_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        side_now = value;
    endtask

    task automatic push_random(input int unsigned count);
        repeat (count) position_q.push_back(pick_position(side_now));
    endtask

    initial begin
        logic [spig_pkg::CFG_W-1:0] sides[NUM_SIDES];
        sides = '{16'd7, 16'd65535, 16'd0, 16'd2, 16'd8, 16'd1, 16'd3,
                  16'd5, 16'd101, 16'd255, 16'd4095, 16'd65534, 16'd999, 16'd40001};
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        pos_if.valid    = 1'b0;
        pos_if.position = '0;
        res_if.ready    = 1'b0;
        side_now        = 16'd1;
        src_idle_pct    = 22;
        sink_idle_pct   = 82;
        hold_go         = 1'b0;
        mismatches      = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset side of one
        position_q.push_back(32'd0);
        position_q.push_back(32'd1);
        position_q.push_back(32'd2);
        position_q.push_back(32'hFFFF_FFFF);
        wait_drained();

        for (int n = 0; n < NUM_SIDES; n++) begin
            if (n == 5) begin
                src_idle_pct  = 82;
                sink_idle_pct = 22;
            end else if (n == 10) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_side(sides[n]);
            if (n == 0) begin
                position_q.push_back(32'd0);
                position_q.push_back(32'd1);
                position_q.push_back(32'd2);
                position_q.push_back(32'd3);
                position_q.push_back(32'd5);
                position_q.push_back(32'd7);
                position_q.push_back(32'd9);
                position_q.push_back(32'd10);
                position_q.push_back(32'd25);
                position_q.push_back(32'd26);
                position_q.push_back(32'd48);
                position_q.push_back(32'd49);
                position_q.push_back(32'd50);
            end else if (n == 1) begin
                position_q.push_back(32'd1);
                position_q.push_back(32'd65535 * 32'd65535);
                position_q.push_back(32'd65535 * 32'd65535 + 32'd1);
                position_q.push_back(32'd65533 * 32'd65533);
                position_q.push_back(32'd65533 * 32'd65533 + 32'd1);
                position_q.push_back(32'hFFFF_FFFF);
                position_q.push_back(32'hAAAA_AAAA);
                position_q.push_back(32'h5555_5555);
            end
            if (n == 11) begin
                push_random(RAND_PER_SET);
                hold_go = 1'b1;
            end else if (n == 12) begin
                push_random(RAND_PER_SET / 2);
                wait_drained();
                push_random(RAND_PER_SET / 2);
            end else begin
                push_random(RAND_PER_SET);
            end
            wait_drained();
        end

        repeat (3 * LATENCY) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_spiral_index_to_grid_position_core: done, clean");
        else
            $display("tb_spiral_index_to_grid_position_core: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_spiral_index_to_grid_position_core: done, errors");
        $finish;
    end

endmodule
